/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// signal holds in the cycle after a condition
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

/* design/drft_pkg.sv */
package drft_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 4096;
  localparam int unsigned CMD_W               = 2;
  localparam int unsigned ID_W                = 63;
  localparam int unsigned VALUE_W             = 64;
  localparam int unsigned IN_TDATA_W          = 128;
  localparam int unsigned OUT_TDATA_W         = 72;

endpackage

/* design/duplicate_request_filter_table_unit.sv */
// Duplicate request filter table: a direct-mapped table of TABLE_DEPTH slots, chosen by the
// low bits of the client id, holding a client tag and the last processed request id per
// slot. After reset a clearing pass zeroes all TABLE_DEPTH slots (4096 by default) with
// s_axis_tready low; configuration writes are taken throughout. For commands 0, 1 and 3
// the accept cycle issues the table read, then ST_CHECK checks the registered read data,
// writes back and loads the result register once that register is free. Command 2 reads
// one slot per cycle through the same read port, from slot (client_id + 1) upward to the
// first occupied one or to the last slot, then waits for a free result register. The
// result register lets the next request be accepted while a result waits to be taken.
module duplicate_request_filter_table_unit
  import drft_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i,     // recovery_mode
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // command, client_id, request_id
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // result_flag, result_value, zero pad
);

  localparam int unsigned AW        = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam int unsigned PAD_W     = OUT_TDATA_W - VALUE_W - 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLAIM = 2'd0,
    CMD_DUP   = 2'd1,
    CMD_NEXT  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN
  } state_e;

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [ID_W-1:0]     cid_q, cid_d;
  logic [ID_W-1:0]     rid_q, rid_d;
  logic [AW-1:0]       slot_q, slot_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic                last_q, last_d;
  logic                recovery_q, recovery_d;
  logic                out_valid_q, out_valid_d;
  logic                out_flag_q, out_flag_d;
  logic [VALUE_W-1:0]  out_value_q, out_value_d;

  cmd_e                in_cmd;
  logic [ID_W-1:0]     in_cid;
  logic [ID_W-1:0]     in_rid;
  logic [AW-1:0]       in_slot;
  logic [AW-1:0]       next_slot;
  logic                accept;
  logic                out_free;

  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic                tag_we;
  logic                last_we;
  logic [AW-1:0]       ram_waddr;
  logic [ID_W-1:0]     tag_wdata;
  logic [ID_W-1:0]     last_wdata;
  logic [ID_W-1:0]     tag_rdata;
  logic [ID_W-1:0]     last_rdata;
  logic                tag_nz;
  logic                chk_flag;
  logic [VALUE_W-1:0]  chk_value;

  assign in_cmd    = cmd_e'(s_axis_tdata[CMD_W-1:0]);
  assign in_cid    = s_axis_tdata[CMD_W+ID_W-1:CMD_W];
  assign in_rid    = s_axis_tdata[CMD_W+2*ID_W-1:CMD_W+ID_W];
  assign in_slot   = in_cid[AW-1:0] & LAST_SLOT;
  assign next_slot = (in_cid[AW-1:0] + AW'(1)) & LAST_SLOT;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign tag_nz        = (tag_rdata != '0);

  // table read port
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = in_slot;
    if (state_q == ST_SCAN) begin
      ram_raddr = addr_q;
      ram_re    = !tag_nz && !last_q;
    end else if (accept) begin
      ram_re    = 1'b1;
      ram_raddr = (in_cmd == CMD_NEXT) ? next_slot : in_slot;
    end
  end

  // check of the registered read data
  always_comb begin
    chk_flag  = 1'b0;
    chk_value = '0;
    unique case (cmd_q)
      CMD_CLAIM: chk_flag = !tag_nz || (tag_rdata == cid_q);
      CMD_DUP:   chk_flag = (cid_q != '0) && (last_rdata >= rid_q);
      CMD_NEXT:  chk_flag = 1'b0;
      CMD_READ: begin
        chk_flag  = (tag_rdata == cid_q);
        chk_value = {1'b0, last_rdata};
      end
      default:   chk_flag = 1'b0;
    endcase
  end

  // write-back and clearing pass
  always_comb begin
    tag_we     = 1'b0;
    last_we    = 1'b0;
    ram_waddr  = slot_q;
    tag_wdata  = cid_q;
    last_wdata = rid_q;
    if (state_q == ST_CLEAR) begin
      tag_we     = 1'b1;
      last_we    = 1'b1;
      ram_waddr  = addr_q;
      tag_wdata  = '0;
      last_wdata = '0;
    end else if (state_q == ST_CHECK && out_free) begin
      tag_we  = (cmd_q == CMD_CLAIM) && !tag_nz;
      last_we = (cmd_q == CMD_DUP) && (cid_q != '0) && !(last_rdata >= rid_q) && !recovery_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cid_d       = cid_q;
    rid_d       = rid_q;
    slot_d      = slot_q;
    addr_d      = addr_q;
    last_d      = last_q;
    recovery_d  = cfg_valid_i ? cfg_data_i : recovery_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_flag_d  = out_flag_q;
    out_value_d = out_value_q;
    unique case (state_q)
      ST_CLEAR: begin
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = in_cmd;
          cid_d  = in_cid;
          rid_d  = in_rid;
          slot_d = in_slot;
          addr_d = next_slot + AW'(1);
          last_d = (next_slot == LAST_SLOT);
          state_d = (in_cmd == CMD_NEXT) ? ST_SCAN : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_flag_d  = chk_flag;
          out_value_d = chk_value;
          state_d     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (tag_nz || last_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_flag_d  = tag_nz;
            out_value_d = tag_nz ? {1'b0, tag_rdata} : '1;
            state_d     = ST_IDLE;
          end
        end else begin
          addr_d = addr_q + AW'(1);
          last_d = (addr_q == LAST_SLOT);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      last_q      <= 1'b0;
      recovery_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      last_q      <= last_d;
      recovery_q  <= recovery_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    cid_q       <= cid_d;
    rid_q       <= rid_d;
    slot_q      <= slot_d;
    out_flag_q  <= out_flag_d;
    out_value_q <= out_value_d;
  end

  drft_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (ram_waddr),
    .wdata_i (tag_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (tag_rdata)
  );

  drft_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_last_ram (
    .clk_i   (clk_i),
    .we_i    (last_we),
    .waddr_i (ram_waddr),
    .wdata_i (last_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (last_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_value_q, out_flag_q};

endmodule

/* design/drft_ram.sv */
module drft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/drft_checker.sv */
`include "assert_macros.svh"

module drft_checker
  import drft_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  `ASSERT_CLK(a_out_valid_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `ASSERT_HOLD(a_out_data_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "result changed while stalled")
  // one request at a time
  `ASSERT_CLK(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")
  // only the not-found answer carries a negative value, and then with a clear flag
  `ASSERT_CLK(a_not_found_flag, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[VALUE_W] |-> !m_axis_tdata[0], "negative value with flag set")

endmodule

bind duplicate_request_filter_table_unit drft_checker u_drft_checker (.*);

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import drft_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int          CYCLE_LIMIT = 6_000_000;
  localparam logic [ID_W-1:0]    ID_MAX    = '1;
  localparam logic [VALUE_W-1:0] NOT_FOUND = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLAIM       = 2'd0,
    CMD_DUP_CHECK   = 2'd1,
    CMD_NEXT_CLIENT = 2'd2,
    CMD_READ_ID     = 2'd3
  } command_e;

  typedef struct packed {
    logic               flag;
    logic [VALUE_W-1:0] value;
  } outcome_t;

  class drft_scoreboard;
    logic [ID_W-1:0] client_tag[TABLE_DEPTH];
    logic [ID_W-1:0] last_request[TABLE_DEPTH];
    bit              recovery;
    outcome_t        pending[$];
    int              mismatches;
    int              results_seen;

    function new();
      foreach (client_tag[i]) begin
        client_tag[i]   = '0;
        last_request[i] = '0;
      end
      recovery     = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_recovery(bit mode);
      recovery = mode;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void note_request(command_e cmd, logic [ID_W-1:0] cid, logic [ID_W-1:0] rid);
      outcome_t          exp;
      int unsigned       slot;
      int unsigned       i;
      logic [VALUE_W-1:0] bumped;
      slot      = int'(cid & ID_W'(TABLE_DEPTH - 1));
      exp.flag  = 1'b0;
      exp.value = '0;
      case (cmd)
        CMD_CLAIM: begin
          if (client_tag[slot] != '0) begin
            exp.flag = (client_tag[slot] == cid);
          end else begin
            client_tag[slot] = cid;
            exp.flag = 1'b1;
          end
        end
        CMD_DUP_CHECK: begin
          if (cid != '0) begin
            if (last_request[slot] >= rid) begin
              exp.flag = 1'b1;
            end else if (!recovery) begin
              last_request[slot] = rid;
            end
          end
        end
        CMD_NEXT_CLIENT: begin
          // start slot may wrap to zero, the walk itself never wraps
          bumped    = {1'b0, cid} + 64'd1;
          exp.value = NOT_FOUND;
          for (i = int'(bumped & VALUE_W'(TABLE_DEPTH - 1)); i < TABLE_DEPTH; i++) begin
            if (client_tag[i] != '0) begin
              exp.flag  = 1'b1;
              exp.value = {1'b0, client_tag[i]};
              break;
            end
          end
        end
        default: begin
          exp.flag  = (client_tag[slot] == cid);
          exp.value = {1'b0, last_request[slot]};
        end
      endcase
      pending.push_back(exp);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      outcome_t exp;
      logic     bad;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d with no request outstanding: %h", results_seen, beat);
        end
        return;
      end
      exp = pending.pop_front();
      bad = (beat[0] !== exp.flag) || (beat[VALUE_W:1] !== exp.value) ||
            (beat[OUT_TDATA_W-1:VALUE_W+1] !== '0);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: flag exp %0b got %0b, value exp %h got %h, pad %h",
                   results_seen, exp.flag, beat[0], exp.value, beat[VALUE_W:1],
                   beat[OUT_TDATA_W-1:VALUE_W+1]);
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // command, client_id, request_id
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // result_flag, result_value, zero pad

  drft_scoreboard  sb;
  bit              idle_on;
  bit              stall_on;
  int              cycles;
  logic [ID_W-1:0] client_pool[POOL_SIZE];
  logic [ID_W-1:0] pool_seq[POOL_SIZE];

  duplicate_request_filter_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: sample before the edge updates, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
    m_axis_tready <= !stall_on || ($urandom_range(99) >= 15);
  end

  function automatic logic [ID_W-1:0] rand_id();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ID_W-1:0];
  endfunction

  task automatic send_request(command_e cmd, logic [ID_W-1:0] cid, logic [ID_W-1:0] rid);
    if (idle_on && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rid, cid, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, cid, rid);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_recovery_mode(bit mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_recovery(mode);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(int count);
    int unsigned     pick;
    int unsigned     p;
    bit              from_pool;
    command_e        cmd;
    logic [ID_W-1:0] cid;
    logic [ID_W-1:0] rid;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 25) cmd = CMD_CLAIM;
      else if (pick < 70) cmd = CMD_DUP_CHECK;
      else if (pick < 80) cmd = CMD_NEXT_CLIENT;
      else cmd = CMD_READ_ID;
      p         = $urandom_range(POOL_SIZE - 1);
      pick      = $urandom_range(99);
      from_pool = (pick < 80);
      if (from_pool) cid = client_pool[p];
      else if (pick < 88) cid = '0;
      else cid = rand_id();
      rid  = rand_id();
      pick = $urandom_range(99);
      if (cmd == CMD_DUP_CHECK && from_pool) begin
        // mostly a growing sequence per client, some replays
        if (pick < 60) begin
          pool_seq[p] = pool_seq[p] + ID_W'($urandom_range(1, 20));
          rid = pool_seq[p];
        end else if (pick < 85) begin
          rid = pool_seq[p] - ID_W'($urandom_range(0, 5));
        end
      end
      send_request(cmd, cid, rid);
    end
  endtask

  initial begin
    sb            = new();
    cycles        = 0;
    idle_on       = 1'b1;
    stall_on      = 1'b1;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      client_pool[i] = rand_id();
      // later entries share a slot with an earlier client
      if (i >= 16) client_pool[i][11:0] = client_pool[i - 16][11:0];
      if (client_pool[i] == '0) client_pool[i] = ID_W'(1);
      pool_seq[i] = ID_W'($urandom_range(0, 1000));
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // written during the clearing pass
    write_recovery_mode(1'b0);

    send_request(CMD_NEXT_CLIENT, '0, '0);
    send_request(CMD_NEXT_CLIENT, ID_MAX, ID_MAX);
    send_request(CMD_CLAIM, '0, ID_MAX);
    send_request(CMD_READ_ID, '0, '0);
    send_request(CMD_CLAIM, ID_MAX, '0);
    send_request(CMD_CLAIM, ID_MAX, '0);
    send_request(CMD_CLAIM, ID_W'(12'hfff), '0);
    send_request(CMD_DUP_CHECK, '0, ID_MAX);
    send_request(CMD_DUP_CHECK, ID_MAX, '0);
    send_request(CMD_DUP_CHECK, ID_MAX, ID_MAX);
    send_request(CMD_DUP_CHECK, ID_MAX, ID_MAX);
    send_request(CMD_DUP_CHECK, ID_W'(12'hfff), ID_W'(5));
    send_request(CMD_READ_ID, ID_MAX, '0);
    send_request(CMD_READ_ID, ID_W'(12'hfff), '0);
    send_request(CMD_NEXT_CLIENT, ID_W'(12'hffe), '0);
    send_request(CMD_NEXT_CLIENT, ID_W'(12'hfff), '0);
    send_request(CMD_CLAIM, ID_W'(16'h1000), '0);
    send_request(CMD_CLAIM, '0, '0);
    send_request(CMD_READ_ID, '0, '0);
    send_request(CMD_NEXT_CLIENT, ID_MAX, '0);
    send_request(CMD_CLAIM, ID_W'(1), '0);
    send_request(CMD_DUP_CHECK, ID_W'(1), ID_W'(7));
    drain();

    write_recovery_mode(1'b1);
    send_request(CMD_DUP_CHECK, ID_W'(1), ID_W'(9));
    send_request(CMD_READ_ID, ID_W'(1), '0);
    send_request(CMD_DUP_CHECK, ID_W'(1), ID_W'(7));
    send_random(120);
    drain();

    // long stretch with both sides always ready
    write_recovery_mode(1'b0);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_random(150);
    drain();

    idle_on  = 1'b1;
    stall_on = 1'b1;
    write_recovery_mode(1'b1);
    send_random(50);
    drain();
    write_recovery_mode(1'b0);
    send_random(60);
    drain();

    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
